FILE: rtl/core/sparse_graph_conv_gradient_core_macros.svh
// Assertion macros shared by the sparse graph convolution gradient core.
// Depends on nothing; included by files that carry concurrent assertions.
// The macros expand to nothing when SYNTHESIS is defined.
`ifndef SPARSE_GRAPH_CONV_GRADIENT_CORE_MACROS_SVH
`define SPARSE_GRAPH_CONV_GRADIENT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define SGCG_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication, checked at every rising edge out of reset.
`define SGCG_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`else
`define SGCG_ASSERT_IMP(label, clk, rst, lhs, rhs, msg)
`define SGCG_ASSERT_NXT(label, clk, rst, lhs, rhs, msg)
`endif
`endif

FILE: rtl/core/sgcg_pkg.sv
// Shared types, codes and arithmetic helpers of the sparse graph gradient core.
// Depends on nothing; imported by the interfaces, front, back and top level of the core.
package sgcg_pkg;

  // Field widths of one command word.
  localparam int FUNC_W  = 3;
  localparam int BATCH_W = 2;
  localparam int NODE_W  = 6;
  localparam int LAYER_W = 2;
  localparam int FEAT_W  = 4;
  localparam int EDGE_W  = 10;
  localparam int VAL_W   = 16;
  localparam int ACC_W   = 64;

  // Store depths and address widths.
  localparam int VADDR_W = BATCH_W + NODE_W + FEAT_W;
  localparam int WADDR_W = LAYER_W + FEAT_W + FEAT_W;
  localparam int VDEPTH  = 1 << VADDR_W;
  localparam int WDEPTH  = 1 << WADDR_W;
  localparam int EDEPTH  = 1 << EDGE_W;

  // Limits of the in-use counts.
  localparam logic [10:0] MAX_EDGES        = 11'd1024;
  localparam logic [4:0]  MAX_IN_FEATURES  = 5'd16;
  localparam logic [4:0]  MAX_OUT_FEATURES = 5'd16;
  localparam logic [6:0]  MAX_NODES        = 7'd64;
  localparam logic [2:0]  MAX_LAYERS       = 3'd4;
  localparam logic [2:0]  MAX_BATCH        = 3'd4;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Command codes.
  localparam logic [FUNC_W-1:0] FN_VTX_LD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_WGT_LD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_UG_LD  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_EDG_LD = 3'd3;
  localparam logic [FUNC_W-1:0] FN_COMP   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_EG_RD  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_VG_RD  = 3'd6;
  localparam logic [FUNC_W-1:0] FN_WG_RD  = 3'd7;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_FEAT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_FEAT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT = 3'd5;

  // One command as it travels through the queue.
  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [BATCH_W-1:0]      batch;
    logic [NODE_W-1:0]       node;
    logic [NODE_W-1:0]       src_node;
    logic [LAYER_W-1:0]      layer;
    logic [FEAT_W-1:0]       feat_in;
    logic [FEAT_W-1:0]       feat_out;
    logic [EDGE_W-1:0]       edge_req;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // One edge table entry.
  typedef struct packed {
    logic [BATCH_W-1:0]      batch;
    logic [NODE_W-1:0]       tgt;
    logic [LAYER_W-1:0]      layer;
    logic [NODE_W-1:0]       src;
    logic signed [VAL_W-1:0] value;
  } edge_t;

  // One gradient store entry: sticky saturation flag and value.
  typedef struct packed {
    logic                    sat;
    logic signed [ACC_W-1:0] val;
  } acc_t;

  // In-use counts, already clamped to their limits.
  typedef struct packed {
    logic [10:0] ne;
    logic [4:0]  nfi;
    logic [4:0]  nfo;
    logic [6:0]  nn;
    logic [2:0]  nl;
    logic [2:0]  nb;
  } cfg_t;

  // Status of the back end seen by the top level.
  typedef struct packed {
    logic computing;
    logic clearing;
  } back_status_t;

  // Saturating accumulate with a sticky flag.
  function automatic acc_t sat_add(acc_t a, logic signed [ACC_W-1:0] x);
    acc_t                    r;
    logic signed [ACC_W-1:0] sum;
    sum = a.val + x;
    r = a;
    if ((a.val[ACC_W-1] == x[ACC_W-1]) && (sum[ACC_W-1] != a.val[ACC_W-1])) begin
      r.sat = 1'b1;
      r.val = x[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r.val = sum;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sgcg_if.sv
// Channel interfaces of the sparse graph gradient core: command and result.
// Depends on sgcg_pkg for the field widths.
interface sgcg_req_if;
  import sgcg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [BATCH_W-1:0]      batch;
  logic [NODE_W-1:0]       node;
  logic [NODE_W-1:0]       src_node;
  logic [LAYER_W-1:0]      layer;
  logic [FEAT_W-1:0]       feat_in;
  logic [FEAT_W-1:0]       feat_out;
  logic [EDGE_W-1:0]       edge_req;
  logic signed [VAL_W-1:0] value;
  modport source(output valid, func, batch, node, src_node, layer, feat_in, feat_out,
                 edge_req, value, input ready);
  modport sink(input valid, func, batch, node, src_node, layer, feat_in, feat_out,
               edge_req, value, output ready);
endinterface

interface sgcg_rsp_if;
  import sgcg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] grad_value;
  logic                    saturated;
  modport source(output valid, grad_value, saturated, input ready);
  modport sink(input valid, grad_value, saturated, output ready);
endinterface

FILE: rtl/core/sgcg_front.sv
// Front end: takes command words and holds them in a short queue for the back end.
// Depends on sgcg_pkg and the sgcg_req_if interface.
module sgcg_front (
  input  logic                  clk,
  input  logic                  rst,
  sgcg_req_if.sink              req,
  output sgcg_pkg::cmd_t        head,
  output logic                  head_valid,
  input  logic                  pop,
  output logic [sgcg_pkg::QCNT_W-1:0] count
);
  import sgcg_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              push;
  logic              do_pop;

  assign req.ready  = (count != QCNT_W'(QDEPTH));
  assign push       = req.valid && req.ready;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = slots[rd_ptr];

  // Payload slots; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{func: req.func, batch: req.batch, node: req.node,
                         src_node: req.src_node, layer: req.layer,
                         feat_in: req.feat_in, feat_out: req.feat_out,
                         edge_req: req.edge_req, value: req.value};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end
endmodule

FILE: rtl/core/sgcg_back.sv
// Back end: operand stores, edge table, gradient stores and the compute sequencer.
// Depends on sgcg_pkg and the sgcg_rsp_if interface.
module sgcg_back (
  input  logic                   clk,
  input  logic                   rst,
  input  sgcg_pkg::cfg_t         cfg,
  input  sgcg_pkg::cmd_t         head,
  input  logic                   head_valid,
  output logic                   pop,
  output sgcg_pkg::back_status_t status,
  sgcg_rsp_if.source             rsp
);
  import sgcg_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RD     = 5'd1;
  localparam logic [4:0] ST_RD_OUT = 5'd2;
  localparam logic [4:0] ST_CLR    = 5'd3;
  localparam logic [4:0] ST_E_RD   = 5'd4;
  localparam logic [4:0] ST_E_CHK  = 5'd5;
  localparam logic [4:0] ST_A_RD   = 5'd6;
  localparam logic [4:0] ST_A_M1   = 5'd7;
  localparam logic [4:0] ST_A_M2   = 5'd8;
  localparam logic [4:0] ST_A_ACC  = 5'd9;
  localparam logic [4:0] ST_A_WR   = 5'd10;
  localparam logic [4:0] ST_B_VRD  = 5'd11;
  localparam logic [4:0] ST_B_VLD  = 5'd12;
  localparam logic [4:0] ST_B_RD   = 5'd13;
  localparam logic [4:0] ST_B_M1   = 5'd14;
  localparam logic [4:0] ST_B_M2   = 5'd15;
  localparam logic [4:0] ST_B_ACC  = 5'd16;
  localparam logic [4:0] ST_B_VWR  = 5'd17;
  localparam logic [4:0] ST_E_NEXT = 5'd18;

  // Stores.
  logic signed [VAL_W-1:0] vtx_mem [VDEPTH];
  logic signed [VAL_W-1:0] wgt_mem [WDEPTH];
  logic signed [VAL_W-1:0] ug_mem  [VDEPTH];
  edge_t                   edg_mem [EDEPTH];
  acc_t                    eg_mem  [EDEPTH];
  acc_t                    vg_mem  [VDEPTH];
  acc_t                    wg_mem  [WDEPTH];

  logic signed [VAL_W-1:0] vtx_q, wgt_q, ug_q;
  edge_t                   edg_q;
  acc_t                    eg_q, vg_q, wg_q;

  // Sequencer registers.
  logic [4:0]         state;
  logic [VADDR_W-1:0] clr;
  logic [10:0]        ecnt;
  logic [FEAT_W-1:0]  f1, f2;
  edge_t              ed;
  cmd_t               rcmd;
  acc_t               eacc, vacc;
  logic signed [31:0] p1a, p1b;
  logic signed [47:0] p2a, p2b;
  logic               grads_valid;
  logic               out_valid;
  acc_t               out_reg;

  logic               f1_last, f2_last, e_last, edge_skip, computing;
  logic [VADDR_W-1:0] vtx_ra, ug_ra, vg_ra, vg_wa;
  logic [WADDR_W-1:0] wgt_ra, wg_ra, wg_wa;
  logic [EDGE_W-1:0]  eg_ra, eg_wa;
  logic               vtx_we, wgt_we, ug_we, edg_we, eg_we, vg_we, wg_we;
  acc_t               eg_wd, vg_wd, wg_wd;
  acc_t               rd_sel;

  assign f1_last   = ({1'b0, f1} + 5'd1) == cfg.nfi;
  assign f2_last   = ({1'b0, f2} + 5'd1) == cfg.nfo;
  assign e_last    = (ecnt + 11'd1) == cfg.ne;
  assign computing = (state != ST_IDLE) && (state != ST_RD) && (state != ST_RD_OUT);
  assign edge_skip = ({1'b0, edg_q.batch} >= cfg.nb) || ({1'b0, edg_q.tgt} >= cfg.nn) ||
                     ({1'b0, edg_q.src} >= cfg.nn) || ({1'b0, edg_q.layer} >= cfg.nl) ||
                     (cfg.nfi == '0) || (cfg.nfo == '0);

  assign status.computing = computing;
  assign status.clearing  = (state == ST_CLR);

  // Take a command from the queue only when the sequencer is idle.
  assign pop = (state == ST_IDLE) && head_valid;

  // Read and write addresses, write enables and write data of all stores.
  always_comb begin
    vtx_ra = {ed.batch, ed.src, f1};
    ug_ra  = {ed.batch, ed.tgt, f2};
    wgt_ra = {ed.layer, f1, f2};
    eg_ra  = rcmd.edge_req;
    vg_ra  = computing ? {ed.batch, ed.src, f1} : {rcmd.batch, rcmd.node, rcmd.feat_in};
    wg_ra  = computing ? {ed.layer, f1, f2} : {rcmd.layer, rcmd.feat_in, rcmd.feat_out};
    vtx_we = pop && (head.func == FN_VTX_LD);
    wgt_we = pop && (head.func == FN_WGT_LD);
    ug_we  = pop && (head.func == FN_UG_LD);
    edg_we = pop && (head.func == FN_EDG_LD);
    eg_we  = 1'b0;
    vg_we  = 1'b0;
    wg_we  = 1'b0;
    eg_wa  = clr[EDGE_W-1:0];
    vg_wa  = clr;
    wg_wa  = clr[WADDR_W-1:0];
    eg_wd  = '0;
    vg_wd  = '0;
    wg_wd  = '0;
    case (state)
      ST_CLR: begin
        eg_we = 1'b1;
        vg_we = 1'b1;
        wg_we = 1'b1;
      end
      ST_A_WR: begin
        eg_we = 1'b1;
        eg_wa = ecnt[EDGE_W-1:0];
        eg_wd = eacc;
      end
      ST_B_ACC: begin
        wg_we = 1'b1;
        wg_wa = {ed.layer, f1, f2};
        wg_wd = sat_add(wg_q, {{16{p2b[47]}}, p2b});
      end
      ST_B_VWR: begin
        vg_we = 1'b1;
        vg_wa = {ed.batch, ed.src, f1};
        vg_wd = vacc;
      end
      default: begin
      end
    endcase
  end

  // Operand stores and edge table, written by load commands.
  always_ff @(posedge clk) begin
    if (vtx_we) vtx_mem[{head.batch, head.node, head.feat_in}] <= head.value;
    vtx_q <= vtx_mem[vtx_ra];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) wgt_mem[{head.layer, head.feat_in, head.feat_out}] <= head.value;
    wgt_q <= wgt_mem[wgt_ra];
  end

  always_ff @(posedge clk) begin
    if (ug_we) ug_mem[{head.batch, head.node, head.feat_out}] <= head.value;
    ug_q <= ug_mem[ug_ra];
  end

  always_ff @(posedge clk) begin
    if (edg_we) begin
      edg_mem[head.edge_req] <= '{batch: head.batch, tgt: head.node, layer: head.layer,
                                  src: head.src_node, value: head.value};
    end
    edg_q <= edg_mem[ecnt[EDGE_W-1:0]];
  end

  // Gradient stores.
  always_ff @(posedge clk) begin
    if (eg_we) eg_mem[eg_wa] <= eg_wd;
    eg_q <= eg_mem[eg_ra];
  end

  always_ff @(posedge clk) begin
    if (vg_we) vg_mem[vg_wa] <= vg_wd;
    vg_q <= vg_mem[vg_ra];
  end

  always_ff @(posedge clk) begin
    if (wg_we) wg_mem[wg_wa] <= wg_wd;
    wg_q <= wg_mem[wg_ra];
  end

  // Selected gradient entry of a read; zero before the first compute.
  always_comb begin
    case (rcmd.func)
      FN_EG_RD: rd_sel = eg_q;
      FN_VG_RD: rd_sel = vg_q;
      default:  rd_sel = wg_q;
    endcase
    if (!grads_valid) rd_sel = '0;
  end

  // Multiplier chains and accumulators.
  always_ff @(posedge clk) begin
    case (state)
      ST_A_M1: p1a <= ug_q * wgt_q;
      ST_A_M2: p2a <= p1a * vtx_q;
      ST_B_M1: begin
        p1a <= ug_q * wgt_q;
        p1b <= ug_q * ed.value;
      end
      ST_B_M2: begin
        p2a <= p1a * ed.value;
        p2b <= p1b * vtx_q;
      end
      default: begin
      end
    endcase
    if (state == ST_E_CHK) eacc <= '0;
    if (state == ST_A_ACC) eacc <= sat_add(eacc, {{16{p2a[47]}}, p2a});
    if (state == ST_B_VLD) vacc <= vg_q;
    if (state == ST_B_ACC) vacc <= sat_add(vacc, {{16{p2a[47]}}, p2a});
    if (state == ST_E_CHK) ed <= edg_q;
    if (pop) rcmd <= head;
    if (state == ST_RD_OUT && (!out_valid || rsp.ready)) out_reg <= rd_sel;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      clr         <= '0;
      ecnt        <= '0;
      f1          <= '0;
      f2          <= '0;
      grads_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (head.func)
              FN_COMP: begin
                state       <= ST_CLR;
                clr         <= '0;
                grads_valid <= 1'b1;
              end
              FN_EG_RD, FN_VG_RD, FN_WG_RD: state <= ST_RD;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_RD: state <= ST_RD_OUT;
        ST_RD_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_CLR: begin
          clr <= clr + 1'b1;
          if (clr == {VADDR_W{1'b1}}) begin
            ecnt  <= '0;
            state <= (cfg.ne == '0) ? ST_IDLE : ST_E_RD;
          end
        end
        ST_E_RD: state <= ST_E_CHK;
        ST_E_CHK: begin
          f1    <= '0;
          f2    <= '0;
          state <= edge_skip ? ST_E_NEXT : ST_A_RD;
        end
        ST_A_RD: state <= ST_A_M1;
        ST_A_M1: state <= ST_A_M2;
        ST_A_M2: state <= ST_A_ACC;
        ST_A_ACC: begin
          // Edge gradient: output feature outer, input feature inner.
          if (f1_last) begin
            f1 <= '0;
            if (f2_last) begin
              f2    <= '0;
              state <= ST_A_WR;
            end else begin
              f2    <= f2 + 1'b1;
              state <= ST_A_RD;
            end
          end else begin
            f1    <= f1 + 1'b1;
            state <= ST_A_RD;
          end
        end
        ST_A_WR:  state <= ST_B_VRD;
        ST_B_VRD: state <= ST_B_VLD;
        ST_B_VLD: state <= ST_B_RD;
        ST_B_RD:  state <= ST_B_M1;
        ST_B_M1:  state <= ST_B_M2;
        ST_B_M2:  state <= ST_B_ACC;
        ST_B_ACC: begin
          if (f2_last) begin
            f2    <= '0;
            state <= ST_B_VWR;
          end else begin
            f2    <= f2 + 1'b1;
            state <= ST_B_RD;
          end
        end
        ST_B_VWR: begin
          if (f1_last) begin
            f1    <= '0;
            state <= ST_E_NEXT;
          end else begin
            f1    <= f1 + 1'b1;
            state <= ST_B_VRD;
          end
        end
        ST_E_NEXT: begin
          if (e_last) begin
            state <= ST_IDLE;
          end else begin
            ecnt  <= ecnt + 1'b1;
            state <= ST_E_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.grad_value = out_reg.val;
  assign rsp.saturated  = out_reg.sat;
endmodule

FILE: rtl/core/sparse_graph_conv_gradient_core.sv
// Top level of the sparse graph convolution gradient core.
// Depends on sgcg_pkg, sgcg_if, sgcg_front, sgcg_back and the assertion macros.
//
//   channel  dir  words          payload
//   req      in   commands       func batch node src_node layer feat_in feat_out edge_req value
//   rsp      out  read results   grad_value saturated
//   cfg      in   register write cfg_we cfg_index cfg_data
//
// A load writes its store as the command is taken; a read passes ST_RD and ST_RD_OUT, then
// its result word is registered. Compute runs a clearing pass over the gradient stores, then
// works through each edge in use, paced by the two-stage multiplier chains.
// A two-word queue takes commands until full while the back end is busy or the result waits.
// Reset is synchronous; reads before the first compute return zero.
module sparse_graph_conv_gradient_core (
  input  logic                               clk,
  input  logic                               rst,
  sgcg_req_if.sink                           req,
  sgcg_rsp_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [sgcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgcg_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import sgcg_pkg::*;
  `include "sparse_graph_conv_gradient_core_macros.svh"

  logic [10:0]       edge_count;
  logic [4:0]        in_feature_count, out_feature_count;
  logic [6:0]        node_count;
  logic [2:0]        layer_count, batch_count;
  cfg_t              cfg;
  cmd_t              head;
  logic              head_valid, pop;
  logic [QCNT_W-1:0] count;
  back_status_t      status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count        <= 11'd0;
      in_feature_count  <= 5'd16;
      out_feature_count <= 5'd16;
      node_count        <= 7'd64;
      layer_count       <= 3'd4;
      batch_count       <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_COUNT:  edge_count        <= cfg_data;
        CFG_IN_FEAT:     in_feature_count  <= cfg_data[4:0];
        CFG_OUT_FEAT:    out_feature_count <= cfg_data[4:0];
        CFG_NODE_COUNT:  node_count        <= cfg_data[6:0];
        CFG_LAYER_COUNT: layer_count       <= cfg_data[2:0];
        CFG_BATCH_COUNT: batch_count       <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Counts in use, clamped to the store sizes.
  always_comb begin
    cfg.ne  = (edge_count < MAX_EDGES) ? edge_count : MAX_EDGES;
    cfg.nfi = (in_feature_count < MAX_IN_FEATURES) ? in_feature_count : MAX_IN_FEATURES;
    cfg.nfo = (out_feature_count < MAX_OUT_FEATURES) ? out_feature_count : MAX_OUT_FEATURES;
    cfg.nn  = (node_count < MAX_NODES) ? node_count : MAX_NODES;
    cfg.nl  = (layer_count < MAX_LAYERS) ? layer_count : MAX_LAYERS;
    cfg.nb  = (batch_count < MAX_BATCH) ? batch_count : MAX_BATCH;
  end

  sgcg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .count      (count)
  );

  sgcg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .status     (status),
    .rsp        (rsp)
  );

  // The queue never holds more words than it has slots.
  `SGCG_ASSERT_IMP(a_q_bound, clk, rst, 1'b1, count <= QCNT_W'(QDEPTH), "queue overfilled")
  // A word taken without a pop grows the queue by one.
  `SGCG_ASSERT_NXT(a_q_push, clk, rst, req.valid && req.ready && !pop,
                   count == $past(count) + 2'd1, "queue count lost a word")
  // No command leaves the queue while compute runs.
  `SGCG_ASSERT_IMP(a_no_pop_busy, clk, rst, status.computing, !pop, "pop during compute")
  // The clearing pass is part of compute.
  `SGCG_ASSERT_IMP(a_clr_busy, clk, rst, status.clearing, status.computing,
                   "clearing outside compute")
endmodule
